// ===== hw/rtl/qtg_pkg.sv =====
// shared types, constants and helpers for the quintic trajectory generator
package qtg_pkg;

   // geometry and field widths
   localparam int AXES      = 3;
   localparam int FRAC_BITS = 24;
   localparam int POS_W     = 23;
   localparam int STATE_W   = 24;
   localparam int PER_W     = 17;
   localparam int DUR_W     = 26;
   localparam int ELA_W     = 27;
   localparam int S_W       = FRAC_BITS + 1;
   localparam int MUL_W     = STATE_W + 2;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 30;
   localparam int OFF_W     = PROD_W - FRAC_BITS;
   localparam int SUM_W     = OFF_W + 1;
   localparam int CNT_W     = $clog2(FRAC_BITS + 1);
   localparam int AX_W      = (AXES > 1) ? $clog2(AXES) : 1;

   // request tdata layout, lowest bits first
   localparam int PER_LSB     = 0;
   localparam int START_LSB   = PER_LSB + PER_W;
   localparam int TARGET_LSB  = START_LSB + AXES * POS_W;
   localparam int DUR_LSB     = TARGET_LSB + AXES * POS_W;
   localparam int REQ_BITS    = DUR_LSB + DUR_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_BITS    = AXES * POS_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // opcodes carried in tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MOVE = 1'b1;

   // fixed-point constants
   localparam logic [S_W-1:0]          ONE_S   = S_W'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) << FRAC_BITS;
   localparam logic signed [MUL_W-1:0] COEF_3  = MUL_W'(10);
   localparam logic signed [MUL_W-1:0] COEF_4  = -MUL_W'(15);
   localparam logic signed [MUL_W-1:0] COEF_5  = MUL_W'(6);
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(4000000);
   localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(4000000);
   localparam logic signed [POS_W-1:0] CMD_MAX = POS_W'(4000000);
   localparam logic signed [POS_W-1:0] CMD_MIN = -POS_W'(4000000);

   // sequencer steps on the shared multiplier
   localparam int STEP_W = $clog2(7 + AXES);
   localparam logic [STEP_W-1:0] STEP_S2   = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_S3   = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_S4   = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_S5   = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_P3   = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_P4   = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_P5   = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_AX0  = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(7 + AXES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_WB,
      ST_OUT
   } seq_state_type;

   // status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic is_move;
      logic tick_ok;
      logic div_done;
      logic out_free;
   } seq_stat_type;

   // controls driven by the sequencer
   typedef struct packed {
      logic              req_ready;
      logic              load_move;
      logic              tick_go;
      logic              div_start;
      logic              mul_en;
      logic              wb_en;
      logic              out_load;
      logic [STEP_W-1:0] step;
   } seq_ctrl_type;

   // sign extend a position field to the stored width
   function automatic logic signed [STATE_W-1:0] sext_pos(input logic [POS_W-1:0] v);
      return {{(STATE_W - POS_W){v[POS_W-1]}}, v};
   endfunction

endpackage

// ===== hw/rtl/qtg_div.sv =====
// iterative restoring divider giving s = elapsed / duration in unsigned q1.24
module qtg_div
   import qtg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ELA_W-1:0] elapsed,
   input  logic [DUR_W-1:0] duration,
   output logic             done,
   output logic [S_W-1:0]   quot
);

   logic [ELA_W-1:0] rem_ff, rem_in;
   logic [S_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ELA_W-1:0] rem2;
   logic [ELA_W-1:0] dur_ext;

   assign dur_ext = ELA_W'(duration);
   assign rem2    = {rem_ff[ELA_W-2:0], 1'b0};

   // one quotient bit per cycle, clamp at one when elapsed reaches duration
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         if (elapsed >= dur_ext) begin
            quo_in  = ONE_S;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in  = elapsed;
            quo_in  = '0;
            cnt_in  = CNT_W'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem2 >= dur_ext) begin
            rem_in = rem2 - dur_ext;
            quo_in = {quo_ff[S_W-2:0], 1'b1};
         end else begin
            rem_in = rem2;
            quo_in = {quo_ff[S_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== hw/rtl/qtg_mul.sv =====
// shared signed multiplier with a registered product
module qtg_mul
   import qtg_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // full-width product, held until the next issue
   always_comb begin
      prod_in = prod_ff;
      if (en) begin
         prod_in = op_a * op_b;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/qtg_seq.sv =====
// sequencer: takes items, runs the divider and steps the shared multiplier
module qtg_seq
   import qtg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output seq_ctrl_type ctrl
);

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_S2;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ctrl      = '0;
      ctrl.step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            if (stat.req_valid) begin
               if (stat.is_move) begin
                  ctrl.load_move = 1'b1;
               end else if (stat.tick_ok) begin
                  ctrl.tick_go = 1'b1;
                  state_in     = ST_START;
               end
            end
         end
         ST_START: begin
            ctrl.div_start = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               step_in  = STEP_S2;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_WB;
         end
         ST_WB: begin
            ctrl.wb_en = 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_OUT;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/quintic_trajectory_generator.sv =====
// three-axis quintic rest-to-rest position interpolator, top level
// an emitting tick runs 24 divider iterations (skipped once elapsed reaches the duration), then
// ten passes through the shared multiplier, each issuing a product in ST_MUL and writing it in ST_WB;
// one item at a time, the next transfer is taken once the result is loaded into the output register
// a move or a non-emitting tick is taken in ST_IDLE; the next item is taken while a result waits
// synchronous reset clears the sequencer, the output valid and all move state (zero duration)
module quintic_trajectory_generator
   import qtg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tick_period, start_x_in, start_y_in, start_z_in, target_x_in, target_y_in,
   // target_z_in, duration_in, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cmd_x, cmd_y, cmd_z, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   seq_stat_type stat;
   seq_ctrl_type ctrl;

   logic signed [STATE_W-1:0] start_ff[AXES], start_in[AXES];
   logic signed [STATE_W-1:0] target_ff[AXES], target_in[AXES];
   logic [DUR_W-1:0]          dur_ff, dur_in;
   logic [ELA_W-1:0]          elapsed_ff, elapsed_in;
   logic [S_W-1:0]            s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in, s5_ff, s5_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [S_W-1:0]            p_ff, p_in;
   logic [POS_W-1:0]          res_ff[AXES], res_in[AXES];
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      div_done;
   logic [S_W-1:0]            s_q;
   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [PROD_W-1:0]  prod;
   logic [STEP_W-1:0]         step_off;
   logic [AX_W-1:0]           ax_idx;
   logic signed [STATE_W:0]   delta;
   logic signed [ACC_W-1:0]   acc_sum;
   logic signed [PROD_W-1:0]  prod_rnd;
   logic signed [OFF_W-1:0]   offset;
   logic signed [SUM_W-1:0]   pos_sum;
   logic [POS_W-1:0]          pos_sat;

   // sequencer status
   assign stat.req_valid = req_tvalid;
   assign stat.is_move   = (req_tuser[0] == OP_MOVE);
   assign stat.tick_ok   = (elapsed_ff < ELA_W'(dur_ff));
   assign stat.div_done  = div_done;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   qtg_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   qtg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .elapsed  (elapsed_ff),
      .duration (dur_ff),
      .done     (div_done),
      .quot     (s_q)
   );

   qtg_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // move state: loaded by a move, elapsed time advanced by an emitting tick
   always_comb begin
      start_in   = start_ff;
      target_in  = target_ff;
      dur_in     = dur_ff;
      elapsed_in = elapsed_ff;
      if (ctrl.load_move) begin
         for (int i = 0; i < AXES; i++) begin
            start_in[i]  = sext_pos(req_tdata[START_LSB + i * POS_W +: POS_W]);
            target_in[i] = sext_pos(req_tdata[TARGET_LSB + i * POS_W +: POS_W]);
         end
         dur_in     = req_tdata[DUR_LSB +: DUR_W];
         elapsed_in = '0;
      end else if (ctrl.tick_go) begin
         elapsed_in = elapsed_ff + ELA_W'(req_tdata[PER_LSB +: PER_W]);
      end
   end

   // axis selected by the current step
   assign step_off = ctrl.step - STEP_AX0;
   assign ax_idx   = step_off[AX_W-1:0];
   assign delta    = {target_ff[ax_idx][STATE_W-1], target_ff[ax_idx]}
                   - {start_ff[ax_idx][STATE_W-1], start_ff[ax_idx]};

   // multiplier operands per step
   always_comb begin
      unique case (ctrl.step)
         STEP_S2: begin
            op_a = signed'({1'b0, s_q});
            op_b = signed'({1'b0, s_q});
         end
         STEP_S3: begin
            op_a = signed'({1'b0, s2_ff});
            op_b = signed'({1'b0, s_q});
         end
         STEP_S4: begin
            op_a = signed'({1'b0, s3_ff});
            op_b = signed'({1'b0, s_q});
         end
         STEP_S5: begin
            op_a = signed'({1'b0, s4_ff});
            op_b = signed'({1'b0, s_q});
         end
         STEP_P3: begin
            op_a = signed'({1'b0, s3_ff});
            op_b = COEF_3;
         end
         STEP_P4: begin
            op_a = signed'({1'b0, s4_ff});
            op_b = COEF_4;
         end
         STEP_P5: begin
            op_a = signed'({1'b0, s5_ff});
            op_b = COEF_5;
         end
         default: begin
            op_a = {delta[STATE_W], delta};
            op_b = signed'({1'b0, p_ff});
         end
      endcase
   end

   // polynomial sum, rounding and saturation of one axis
   assign acc_sum  = acc_ff + prod[ACC_W-1:0];
   assign prod_rnd = prod + HALF_LSB;
   assign offset   = prod_rnd[PROD_W-1:FRAC_BITS];
   assign pos_sum  = SUM_W'(start_ff[ax_idx]) + SUM_W'(offset);

   always_comb begin
      if (pos_sum > POS_MAX) begin
         pos_sat = CMD_MAX;
      end else if (pos_sum < POS_MIN) begin
         pos_sat = CMD_MIN;
      end else begin
         pos_sat = pos_sum[POS_W-1:0];
      end
   end

   // write back the registered product
   always_comb begin
      s2_in  = s2_ff;
      s3_in  = s3_ff;
      s4_in  = s4_ff;
      s5_in  = s5_ff;
      acc_in = acc_ff;
      p_in   = p_ff;
      res_in = res_ff;
      if (ctrl.wb_en) begin
         unique case (ctrl.step)
            STEP_S2: s2_in  = prod[FRAC_BITS +: S_W];
            STEP_S3: s3_in  = prod[FRAC_BITS +: S_W];
            STEP_S4: s4_in  = prod[FRAC_BITS +: S_W];
            STEP_S5: s5_in  = prod[FRAC_BITS +: S_W];
            STEP_P3: acc_in = prod[ACC_W-1:0];
            STEP_P4: acc_in = acc_sum;
            STEP_P5: begin
               // clamp the blend to [0, 1]
               if (acc_sum < 0) begin
                  p_in = '0;
               end else if (acc_sum > ONE_ACC) begin
                  p_in = ONE_S;
               end else begin
                  p_in = acc_sum[S_W-1:0];
               end
            end
            default: res_in[ax_idx] = pos_sat;
         endcase
      end
   end

   // output register, loaded once the previous result has been or is being taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (ctrl.out_load) begin
         rsp_data_in = '0;
         for (int i = 0; i < AXES; i++) begin
            rsp_data_in[i * POS_W +: POS_W] = res_ff[i];
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            start_ff[i]  <= '0;
            target_ff[i] <= '0;
         end
         dur_ff       <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         target_ff    <= target_in;
         dur_ff       <= dur_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      s4_ff       <= s4_in;
      s5_ff       <= s5_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = ctrl.req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/qtg_checker.sv =====
// port-level checks for the quintic trajectory generator, bound to the top level
module qtg_checker
   import qtg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [0:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // every position lies within the saturation limits
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[0 +: POS_W]) <= CMD_MAX &&
         $signed(rsp_tdata[0 +: POS_W]) >= CMD_MIN &&
         $signed(rsp_tdata[POS_W +: POS_W]) <= CMD_MAX &&
         $signed(rsp_tdata[POS_W +: POS_W]) >= CMD_MIN &&
         $signed(rsp_tdata[2 * POS_W +: POS_W]) <= CMD_MAX &&
         $signed(rsp_tdata[2 * POS_W +: POS_W]) >= CMD_MIN)
      else $error("position outside limits");

   // a move transfer never creates a result
   a_move_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == OP_MOVE && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after move transfer");

   // zero fill above the packed positions
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_BITS] == '0)
      else $error("response fill bits not zero");

endmodule

bind quintic_trajectory_generator qtg_checker u_qtg_checker (.*);

// ===== verif/qtg_position_checker.sv =====
// tracks move state from request transfers and checks every interpolated position
`timescale 1ns / 100ps

module qtg_position_checker
   import qtg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // tick_period, start_x_in, start_y_in, start_z_in, target_x_in, target_y_in,
   // target_z_in, duration_in, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [0:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cmd_x, cmd_y, cmd_z, zero fill
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatch_count,
   output int                    positions_pending
);

   localparam int REPORT_LIMIT = 10;

   // mirrored move state
   logic signed [STATE_W-1:0] move_start [AXES];
   logic signed [STATE_W-1:0] move_target [AXES];
   logic [DUR_W-1:0]          move_dur;
   logic [ELA_W-1:0]          move_elapsed;

   // positions still owed by the block, oldest first, x in the low bits
   logic [RSP_BITS-1:0] expected_positions [$];
   int                  results_seen;

   always @(posedge clock) begin : track
      logic [63:0]         s_q, s2, s3, s4, s5;
      longint              blend, delta, offset, pos;
      logic [RSP_BITS-1:0] want, got;
      int                  a;
      if (reset) begin
         for (a = 0; a < AXES; a++) begin
            move_start[a]  = '0;
            move_target[a] = '0;
         end
         move_dur          = '0;
         move_elapsed      = '0;
         results_seen      = 0;
         mismatch_count    = 0;
         positions_pending = 0;
         expected_positions.delete();
      end else begin
         // result side first, a tick never completes on its own transfer edge
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (expected_positions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d: unexpected transfer %h, none pending",
                           results_seen, got);
            end else begin
               want = expected_positions.pop_front();
               for (a = 0; a < AXES; a++) begin
                  if (got[a*POS_W +: POS_W] !== want[a*POS_W +: POS_W]) begin
                     mismatch_count++;
                     if (mismatch_count <= REPORT_LIMIT)
                        $display("result %0d axis %0d: expected %0d, got %0d",
                                 results_seen, a,
                                 $signed(want[a*POS_W +: POS_W]),
                                 $signed(got[a*POS_W +: POS_W]));
                  end
               end
            end
            results_seen++;
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_MOVE) begin
               // load a new move and restart the clock
               for (a = 0; a < AXES; a++) begin
                  move_start[a]  = $signed(req_tdata[START_LSB + a*POS_W +: POS_W]);
                  move_target[a] = $signed(req_tdata[TARGET_LSB + a*POS_W +: POS_W]);
               end
               move_dur     = req_tdata[DUR_LSB +: DUR_W];
               move_elapsed = '0;
            end else if (move_elapsed < ELA_W'(move_dur)) begin
               // advance time and take the normalized phase, clamped at one
               move_elapsed = move_elapsed + ELA_W'(req_tdata[PER_LSB +: PER_W]);
               s_q = (64'(move_elapsed) << FRAC_BITS) / 64'(move_dur);
               if (s_q > 64'(ONE_S))
                  s_q = 64'(ONE_S);

               // minimum-jerk blend 10s^3 - 15s^4 + 6s^5, powers floored
               s2 = (s_q * s_q) >> FRAC_BITS;
               s3 = (s2 * s_q) >> FRAC_BITS;
               s4 = (s3 * s_q) >> FRAC_BITS;
               s5 = (s4 * s_q) >> FRAC_BITS;
               blend = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
               if (blend < 0)
                  blend = 0;
               if (blend > longint'(ONE_S))
                  blend = longint'(ONE_S);

               // scale the travel, round half up, saturate per axis
               for (a = 0; a < AXES; a++) begin
                  delta  = longint'(move_target[a]) - longint'(move_start[a]);
                  offset = (delta * blend + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                  pos    = longint'(move_start[a]) + offset;
                  if (pos > longint'(CMD_MAX))
                     pos = longint'(CMD_MAX);
                  if (pos < longint'(CMD_MIN))
                     pos = longint'(CMD_MIN);
                  want[a*POS_W +: POS_W] = pos[POS_W-1:0];
               end
               expected_positions = {expected_positions, want};
            end
         end
         positions_pending = expected_positions.size();
      end
   end

endmodule

// ===== verif/tb_top.sv =====
// stimulus and verdict for the quintic trajectory generator
`timescale 1ns / 100ps

module tb_top;
   import qtg_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 100;
   localparam int PERIOD_MAX   = (1 << PER_W) - 1;
   localparam int DUR_MAX      = (1 << DUR_W) - 1;
   localparam int RAW_POS_MAX  = (1 << (POS_W - 1)) - 1;
   localparam int RAW_POS_MIN  = -(1 << (POS_W - 1));
   localparam int POS_LIMIT    = 4000000;
   localparam int MOVE_TICK_CAP = 20;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tick_period, start_x_in, start_y_in, start_z_in, target_x_in, target_y_in,
   // target_z_in, duration_in, zero fill
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // opcode
   logic [0:0]            req_tuser  = OP_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // cmd_x, cmd_y, cmd_z, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int positions_pending;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;

   quintic_trajectory_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   qtg_position_checker position_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .mismatch_count    (mismatch_count),
      .positions_pending (positions_pending)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // three positions packed x first
   function automatic logic [AXES*POS_W-1:0] xyz(input int x, input int y, input int z);
      return {POS_W'(z), POS_W'(y), POS_W'(x)};
   endfunction

   // mostly in range, sometimes the limits or any 23-bit value
   function automatic logic [POS_W-1:0] random_pos();
      case ($urandom_range(0, 15))
         0: return POS_W'(POS_LIMIT);
         1: return POS_W'(-POS_LIMIT);
         2: return POS_W'($urandom);
         default: return POS_W'($urandom_range(0, 2 * POS_LIMIT) - POS_LIMIT);
      endcase
   endfunction

   // one request transfer, with random gaps ahead of it
   task automatic send_item(input logic op, input logic [REQ_BITS-1:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(payload);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   // tick: unused fields carry noise
   task automatic send_tick(input int period);
      logic [REQ_BITS-1:0] payload;
      payload = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      payload[PER_LSB +: PER_W] = PER_W'(period);
      send_item(OP_TICK, payload);
   endtask

   task automatic send_move(input logic [AXES*POS_W-1:0] starts,
                            input logic [AXES*POS_W-1:0] targets, input int dur);
      logic [REQ_BITS-1:0] payload;
      payload = '0;
      payload[PER_LSB +: PER_W]           = PER_W'($urandom);
      payload[START_LSB +: AXES*POS_W]    = starts;
      payload[TARGET_LSB +: AXES*POS_W]   = targets;
      payload[DUR_LSB +: DUR_W]           = DUR_W'(dur);
      send_item(OP_MOVE, payload);
   endtask

   // a move followed by ticks that usually carry it past its end
   task automatic run_random_move();
      logic [AXES*POS_W-1:0] starts, targets;
      int                    dur, period, base, steps, ticks;
      longint                elapsed;
      int                    a;
      for (a = 0; a < AXES; a++) begin
         starts[a*POS_W +: POS_W]  = random_pos();
         targets[a*POS_W +: POS_W] = ($urandom_range(0, 9) == 0) ?
                                     starts[a*POS_W +: POS_W] : random_pos();
      end
      case ($urandom_range(0, 19))
         0:            dur = 0;
         1, 2, 3, 4, 5: dur = $urandom_range(1, 2000);
         16, 17, 18:   dur = $urandom_range(1500000, 60000000);
         19:           dur = $urandom_range(60000000, DUR_MAX);
         default:      dur = $urandom_range(2000, 1500000);
      endcase
      send_move(starts, targets, dur);

      steps   = $urandom_range(1, 16);
      base    = dur / steps;
      elapsed = 0;
      ticks   = 0;
      while (elapsed < dur && ticks < MOVE_TICK_CAP) begin
         case ($urandom_range(0, 15))
            0:       period = 0;
            1:       period = $urandom_range(0, PERIOD_MAX);
            default: period = base + $urandom_range(0, base / 4 + 1);
         endcase
         if (period > PERIOD_MAX)
            period = PERIOD_MAX;
         send_tick(period);
         elapsed += period;
         ticks++;
      end
      // stray tick after the move has finished
      if ($urandom_range(0, 3) == 0)
         send_tick($urandom_range(0, PERIOD_MAX));
   endtask

   // stimulus and verdict
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 36;
      recv_idle_pct <= 66;

      // tick right after reset: zero duration, no result
      send_tick(100000);
      // full span move: zero period, steady progress, overshoot, then done
      send_move(xyz(-POS_LIMIT, -POS_LIMIT, -POS_LIMIT),
                xyz(POS_LIMIT, POS_LIMIT, POS_LIMIT), 1000);
      send_tick(0);
      send_tick(250);
      send_tick(500);
      send_tick(300);
      send_tick(100);
      // positions beyond the limits saturate
      send_move(xyz(RAW_POS_MAX, RAW_POS_MIN, 0), xyz(RAW_POS_MIN, RAW_POS_MAX, 0),
                60000000);
      send_tick(PERIOD_MAX);
      send_tick(100000);
      // zero duration move never emits
      send_move(xyz(100, -100, 7), xyz(-100, 100, -7), 0);
      send_tick(5000);
      // longest duration with the longest tick
      send_move(xyz(1234567, -2500000, POS_LIMIT), xyz(-3999999, 2500000, -POS_LIMIT),
                DUR_MAX);
      send_tick(PERIOD_MAX);
      // one microsecond move
      send_move(xyz(3, -3, 0), xyz(-3, 3, 1), 1);
      send_tick(0);
      send_tick(1);
      send_tick(1);
      // standing still outside the limits
      send_move(xyz(RAW_POS_MIN, RAW_POS_MAX, RAW_POS_MIN),
                xyz(RAW_POS_MIN, RAW_POS_MAX, RAW_POS_MIN), 3);
      send_tick(1);
      send_tick(1);
      send_tick(1);

      // random moves under three idle patterns
      while (items_sent < 270)
         run_random_move();
      send_idle_pct = 66;
      recv_idle_pct <= 36;
      while (items_sent < 520)
         run_random_move();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      while (items_sent < 770)
         run_random_move();
      req_tvalid <= 1'b0;

      // drain, then let stray results show up
      @(posedge clock);
      while (positions_pending != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && positions_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/qtg_pkg.sv
hw/rtl/qtg_div.sv
hw/rtl/qtg_mul.sv
hw/rtl/qtg_seq.sv
hw/rtl/quintic_trajectory_generator.sv
hw/rtl/qtg_checker.sv
verif/qtg_position_checker.sv
verif/tb_top.sv
